// ===== rtl/pcx_pkg.sv =====
// Shared types, constants and the run-code helper for the PCX line encoder.
// No dependencies; imported by every module of the block.
package pcx_pkg;

	localparam logic [5:0] MAX_RUN     = 6'd63;
	localparam logic [7:0] COUNT_MARK  = 8'hC0;
	localparam int         QUEUE_DEPTH = 4;
	localparam int         QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int         QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	// Up to four code bytes caused by one input word.
	typedef struct packed {
		logic [3:0][7:0] bytes;
		logic [2:0]      cnt;
	} code_cmd_t;

	// Code bytes of one finished run.
	typedef struct packed {
		logic [1:0][7:0] bytes;
		logic [1:0]      cnt;
	} run_code_t;

	// Encode a run: nothing when empty, literal for a plain single byte,
	// else count byte then value.
	function automatic run_code_t run_code(input logic [7:0] val, input logic [5:0] len);
		run_code_t rc;
		rc.bytes = '0;
		rc.cnt   = 2'd0;
		if (len == 6'd0) begin
			rc.cnt = 2'd0;
		end else if (len == 6'd1 && (val & COUNT_MARK) != COUNT_MARK) begin
			rc.bytes[0] = val;
			rc.cnt      = 2'd1;
		end else begin
			rc.bytes[0] = COUNT_MARK | {2'b00, len};
			rc.bytes[1] = val;
			rc.cnt      = 2'd2;
		end
		return rc;
	endfunction

endpackage

// ===== rtl/pcx_front.sv =====
// Front end: accepts data words, tracks the current run and forms the
// code bytes each word causes. Depends on pcx_pkg.
module pcx_front (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               take,
	input  logic [7:0]         data_byte,
	input  logic               line_end,
	output pcx_pkg::code_cmd_t cmd,
	output logic               cmd_valid
);
	import pcx_pkg::*;

	logic [7:0] run_value_q;
	logic [5:0] run_length_q;
	logic       line_open_q;

	logic [7:0] nxt_value;
	logic [5:0] nxt_length;
	run_code_t  first_rc;
	run_code_t  end_rc;

	// Run update for this word, and the first group of code bytes
	always_comb begin
		first_rc   = '0;
		nxt_value  = run_value_q;
		nxt_length = run_length_q;
		if (!line_open_q) begin
			nxt_value  = data_byte;
			nxt_length = 6'd1;
		end else if (data_byte == run_value_q) begin
			if (run_length_q == MAX_RUN - 6'd1) begin
				first_rc.bytes[0] = COUNT_MARK | {2'b00, MAX_RUN};
				first_rc.bytes[1] = run_value_q;
				first_rc.cnt      = 2'd2;
				nxt_length        = 6'd0;
			end else begin
				nxt_length = run_length_q + 6'd1;
			end
		end else begin
			first_rc   = run_code(run_value_q, run_length_q);
			nxt_value  = data_byte;
			nxt_length = 6'd1;
		end
	end

	// Line end flushes what is left of the run
	always_comb begin
		end_rc = '0;
		if (line_end) begin
			end_rc = run_code(nxt_value, nxt_length);
		end
	end

	// Pack both groups into one command
	always_comb begin
		cmd       = '0;
		cmd.cnt   = {1'b0, first_rc.cnt} + {1'b0, end_rc.cnt};
		cmd.bytes[0] = first_rc.bytes[0];
		cmd.bytes[1] = first_rc.bytes[1];
		if (first_rc.cnt == 2'd0) begin
			cmd.bytes[0] = end_rc.bytes[0];
			cmd.bytes[1] = end_rc.bytes[1];
		end else if (first_rc.cnt == 2'd1) begin
			cmd.bytes[1] = end_rc.bytes[0];
			cmd.bytes[2] = end_rc.bytes[1];
		end else begin
			cmd.bytes[2] = end_rc.bytes[0];
			cmd.bytes[3] = end_rc.bytes[1];
		end
		cmd_valid = take && (cmd.cnt != 3'd0);
	end

	// Run state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_value_q  <= 8'd0;
			run_length_q <= 6'd0;
			line_open_q  <= 1'b0;
		end else if (take) begin
			run_value_q  <= nxt_value;
			run_length_q <= line_end ? 6'd0 : nxt_length;
			line_open_q  <= !line_end;
		end
	end

endmodule

// ===== rtl/pcx_queue.sv =====
// Short command queue between front and back end, register based.
// Depends on pcx_pkg.
module pcx_queue (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	input  pcx_pkg::code_cmd_t push_cmd,
	input  logic               pop,
	output pcx_pkg::code_cmd_t head_cmd,
	output logic               not_empty,
	output logic               not_full
);
	import pcx_pkg::*;

	code_cmd_t           entry_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0]   wr_ptr_q;
	logic [QPTR_W-1:0]   rd_ptr_q;
	logic [QCNT_W-1:0]   count_q;

	function automatic logic [QPTR_W-1:0] ptr_inc(input logic [QPTR_W-1:0] p);
		return (p == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + QPTR_W'(1);
	endfunction

	assign not_empty = (count_q != '0);
	assign not_full  = (count_q != QCNT_W'(QUEUE_DEPTH));
	assign head_cmd  = entry_q[rd_ptr_q];

	// Entry storage
	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_cmd;
		end
	end

	// Pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= ptr_inc(wr_ptr_q);
			end
			if (pop) begin
				rd_ptr_q <= ptr_inc(rd_ptr_q);
			end
			if (push && !pop) begin
				count_q <= count_q + QCNT_W'(1);
			end else if (pop && !push) begin
				count_q <= count_q - QCNT_W'(1);
			end
		end
	end

endmodule

// ===== rtl/pcx_back.sv =====
// Back end: walks the head command one code byte per word and flags the
// last byte. Depends on pcx_pkg.
module pcx_back (
	input  logic               clk,
	input  logic               arst_n,
	input  pcx_pkg::code_cmd_t head_cmd,
	input  logic               head_valid,
	output logic               pop,
	output logic [7:0]         code_byte,
	output logic               last,
	output logic               code_valid,
	input  logic               code_ready
);
	import pcx_pkg::*;

	logic [1:0] idx_q;

	assign code_valid = head_valid;
	assign code_byte  = head_cmd.bytes[idx_q];
	assign last       = ({1'b0, idx_q} == head_cmd.cnt - 3'd1);
	assign pop        = code_valid && code_ready && last;

	// Byte index within the head command
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q <= 2'd0;
		end else if (code_valid && code_ready) begin
			idx_q <= last ? 2'd0 : idx_q + 2'd1;
		end
	end

endmodule

// ===== rtl/pcx_rle_line_encoder.sv =====
// Top level of the PCX run-length line encoder: front end, command queue
// and back end. Depends on pcx_pkg, pcx_front, pcx_queue, pcx_back.
//
//  channel  | handshake               | payload
//  ---------+-------------------------+----------------------
//  data     | data_valid / data_ready | data_byte, line_end
//  code     | code_valid / code_ready | code_byte, last
//
// One data word is taken per cycle while the command queue has room; each
// word's code bytes (zero to four) go out one per cycle from the back end
// while code_ready is high, so the output port sets the sustained rate on
// runs that break often. Code bytes are registered in the command queue.
// Reset clears the run state and empties the queue; the two sides stall
// independently, up to four commands deep.
module pcx_rle_line_encoder (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       data_valid,
	output logic       data_ready,
	input  logic [7:0] data_byte,
	input  logic       line_end,
	output logic       code_valid,
	input  logic       code_ready,
	output logic [7:0] code_byte,
	output logic       last
);
	import pcx_pkg::*;

	code_cmd_t front_cmd;
	code_cmd_t head_cmd;
	logic      front_push;
	logic      head_valid;
	logic      q_not_full;
	logic      q_pop;
	logic      take;

	assign data_ready = q_not_full;
	assign take       = data_valid && data_ready;

	pcx_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.take      (take),
		.data_byte (data_byte),
		.line_end  (line_end),
		.cmd       (front_cmd),
		.cmd_valid (front_push)
	);

	pcx_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (front_push),
		.push_cmd  (front_cmd),
		.pop       (q_pop),
		.head_cmd  (head_cmd),
		.not_empty (head_valid),
		.not_full  (q_not_full)
	);

	pcx_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_cmd   (head_cmd),
		.head_valid (head_valid),
		.pop        (q_pop),
		.code_byte  (code_byte),
		.last       (last),
		.code_valid (code_valid),
		.code_ready (code_ready)
	);

endmodule

// ===== tb/pcx_rle_code_check_pkg.sv =====
// Code-byte scoreboard for the PCX run-length line encoder test: run predictor
// and store of expected code bytes. Depends on pcx_pkg for the run constants.
package pcx_rle_code_check_pkg;

	import pcx_pkg::*;

	typedef struct packed {
		logic [7:0] code;
		logic       last;
	} code_t;

	class code_scoreboard;
		code_t      expected_codes[$];
		logic [7:0] run_val;
		logic [5:0] run_len;
		logic       line_open;
		int         errors;

		function new();
			run_val   = 8'h00;
			run_len   = 6'd0;
			line_open = 1'b0;
			errors    = 0;
		endfunction

		function int pending();
			return expected_codes.size();
		endfunction

		function void push_code(logic [7:0] b);
			code_t c;
			c.code = b;
			c.last = 1'b0;
			expected_codes.push_back(c);
		endfunction

		// Emit the pending run, if any: plain single bytes go out bare
		function void close_run();
			if (run_len == 6'd0) begin
				return;
			end
			if (run_len == 6'd1 && (run_val & COUNT_MARK) != COUNT_MARK) begin
				push_code(run_val);
			end else begin
				push_code(COUNT_MARK | {2'b00, run_len});
				push_code(run_val);
			end
			run_len = 6'd0;
		endfunction

		// Predict the code bytes caused by one accepted data word
		function void note_word(logic [7:0] b, logic line_end);
			int n_prior;
			n_prior = expected_codes.size();
			if (!line_open) begin
				// first byte of a line opens a fresh run
				run_val   = b;
				run_len   = 6'd1;
				line_open = 1'b1;
			end else if (b == run_val) begin
				run_len = run_len + 6'd1;
				if (run_len >= MAX_RUN) begin
					push_code(COUNT_MARK | {2'b00, MAX_RUN});
					push_code(run_val);
					run_len = 6'd0;
				end
			end else begin
				close_run();
				run_val = b;
				run_len = 6'd1;
			end
			if (line_end) begin
				close_run();
				line_open = 1'b0;
			end
			if (expected_codes.size() > n_prior) begin
				expected_codes[expected_codes.size() - 1].last = 1'b1;
			end
		endfunction

		task flag_mismatch(string msg);
			$display("%0t: mismatch: %s", $time, msg);
			errors++;
		endtask

		// Compare one accepted code byte with the oldest expectation
		task check_code(logic [7:0] code, logic last);
			code_t exp_c;
			if (expected_codes.size() == 0) begin
				flag_mismatch($sformatf("code byte %h last %b with nothing expected",
					code, last));
				return;
			end
			exp_c = expected_codes.pop_front();
			if (code !== exp_c.code) begin
				flag_mismatch($sformatf("code_byte %h, expected %h", code, exp_c.code));
			end
			if (last !== exp_c.last) begin
				flag_mismatch($sformatf("last %b, expected %b on code byte %h",
					last, exp_c.last, exp_c.code));
			end
		endtask
	endclass

endpackage

// ===== tb/pcx_rle_line_encoder_test.sv =====
// Self-checking test of pcx_rle_line_encoder: directed and random scanlines,
// random idling on both channels. Depends on pcx_pkg, pcx_rle_code_check_pkg.
module pcx_rle_line_encoder_test;

	import pcx_rle_code_check_pkg::*;

	logic       clk;
	logic       arst_n;
	logic       data_valid;
	logic       data_ready;
	logic [7:0] data_byte;
	logic       line_end;
	logic       code_valid;
	logic       code_ready;
	logic [7:0] code_byte;
	logic       last;

	code_scoreboard sb;
	int             words_sent;
	bit             tx_quiet;
	bit             rx_quiet;

	pcx_rle_line_encoder dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.data_valid (data_valid),
		.data_ready (data_ready),
		.data_byte  (data_byte),
		.line_end   (line_end),
		.code_valid (code_valid),
		.code_ready (code_ready),
		.code_byte  (code_byte),
		.last       (last)
	);

	initial clk = 1'b0;
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic int pick_wait(bit quiet);
		return quiet ? 0 : $urandom_range(0, 10);
	endfunction

	// Offer one data word; starts and ends at a falling edge
	task automatic send_word(logic [7:0] b, logic e);
		int gap;
		gap = pick_wait(tx_quiet);
		if (gap > 0) begin
			data_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		data_valid <= 1'b1;
		data_byte  <= b;
		line_end   <= e;
		do @(posedge clk); while (!data_ready);
		sb.note_word(b, e);
		words_sent++;
		@(negedge clk);
	endtask

	task automatic send_run(logic [7:0] val, int len, bit close_line);
		for (int i = 0; i < len; i++) begin
			send_word(val, close_line && i == len - 1);
		end
	endtask

	// Stop offering words until every expected code byte has come out
	task automatic hold_until_drained();
		data_valid <= 1'b0;
		do @(negedge clk); while (sb.pending() != 0);
	endtask

	function automatic logic [7:0] pick_value();
		logic [7:0] edge_vals [6];
		edge_vals = '{8'h00, 8'hFF, 8'hC0, 8'hBF, 8'h3F, 8'h40};
		if ($urandom_range(0, 3) == 0) begin
			return edge_vals[$urandom_range(0, 5)];
		end
		return 8'($urandom_range(0, 255));
	endfunction

	function automatic int pick_run_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 2) begin
			return $urandom_range(60, 70);
		end else if (r < 10) begin
			return $urandom_range(5, 20);
		end
		return $urandom_range(1, 4);
	endfunction

	// Code channel: random stalls, every accepted byte goes to the scoreboard
	initial begin
		code_ready = 1'b0;
		wait (arst_n === 1'b1);
		@(negedge clk);
		forever begin
			int stall;
			if ($urandom_range(0, 24) == 0) begin
				rx_quiet = !rx_quiet;
			end
			stall = pick_wait(rx_quiet);
			if (stall > 0) begin
				code_ready <= 1'b0;
				repeat (stall) @(negedge clk);
			end
			code_ready <= 1'b1;
			do @(posedge clk); while (!code_valid);
			sb.check_code(code_byte, last);
			@(negedge clk);
		end
	end

	// Stimulus
	initial begin
		logic [7:0] a;
		int         n_runs;
		sb         = new();
		words_sent = 0;
		tx_quiet   = 1'b0;
		rx_quiet   = 1'b0;
		arst_n     = 1'b0;
		data_valid = 1'b0;
		data_byte  = 8'h00;
		line_end   = 1'b0;
		repeat (4) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// single-byte lines at both extremes
		send_word(8'h00, 1'b1);
		send_word(8'hFF, 1'b1);
		// literal boundary, run with top bits set, literal at line end
		send_word(8'hBF, 1'b0);
		send_run(8'hC0, 2, 1'b0);
		send_word(8'h3F, 1'b1);
		// new line starting on the previous line's run byte
		send_run(8'h3F, 2, 1'b1);
		// literals, then a lone byte with top bits set
		send_word(8'h55, 1'b0);
		send_word(8'hAA, 1'b0);
		send_word(8'h01, 1'b0);
		send_word(8'h80, 1'b0);
		send_word(8'hC5, 1'b1);
		send_run(8'h12, 3, 1'b1);
		tx_quiet = 1'b1;
		send_word(8'h7F, 1'b0);
		send_word(8'hFE, 1'b0);
		send_run(8'h01, 2, 1'b1);
		tx_quiet = 1'b0;
		hold_until_drained();

		// full-length run, then a different byte that closes nothing
		a = 8'($urandom_range(0, 255));
		send_run(a, 63, 1'b0);
		send_word(8'(a + $urandom_range(1, 255)), 1'b1);
		// full-length run right at the line end
		send_run(8'($urandom_range(0, 255)), 63, 1'b1);
		hold_until_drained();

		// random scanlines built from runs
		while (words_sent < 380) begin
			tx_quiet = ($urandom_range(0, 3) == 0);
			n_runs   = $urandom_range(1, 6);
			for (int r = 0; r < n_runs; r++) begin
				send_run(pick_value(), pick_run_len(), r == n_runs - 1);
			end
			if ($urandom_range(0, 14) == 0) begin
				hold_until_drained();
			end
		end

		hold_until_drained();
		repeat (20) @(negedge clk);
		if (sb.errors == 0 && sb.pending() == 0) begin
			$display("pcx_rle_line_encoder_test: PASS");
		end else begin
			$display("pcx_rle_line_encoder_test: FAIL");
		end
		$finish;
	end

	// Watchdog
	initial begin
		#5000000;
		$display("pcx_rle_line_encoder_test: FAIL");
		$finish;
	end

endmodule
